// ===== hdl/sadf_pkg.sv =====
// ----------------------------------------------------------------------------
// sadf_pkg: shared types and constants for the slot allocator
// Field widths, result codes, action codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package sadf_pkg;

    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int ACTION_W   = 2;
    localparam int FRAME_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int SLOTS_DEF       = 1024;
    localparam int MAX_FRAMES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int FRAME_COUNT_RST = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED  = 3'd0,
        ST_POOL_EMPTY = 3'd1,
        ST_WRITE_FAIL = 3'd2,
        ST_QUEUED     = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_CLEARED    = 3'd5,
        ST_NOTHING    = 3'd6,
        ST_BAD        = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } t_state;

endpackage

// ===== hdl/slot_allocator_deferred_free_top.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_deferred_free_top: free-list slot allocator, per-frame release
// Allocate and release give a registered result beat once S_EXEC sees the
// output free; no new request is taken until the block is back in S_IDLE.
// Flush sends queued slots from the queue RAM one beat a cycle unless stalled.
// Synchronous active-low reset; the stack reads as refilled at once through a
// low-water mark, so there is no clearing pass after reset or a slot_count write.
// ----------------------------------------------------------------------------
module slot_allocator_deferred_free_top #(
    parameter int SLOTS       = sadf_pkg::SLOTS_DEF,
    parameter int MAX_FRAMES  = sadf_pkg::MAX_FRAMES_DEF,
    parameter int QUEUE_DEPTH = sadf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sadf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sadf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sadf_pkg::ACTION_W-1:0]     i_action,
    input  logic [sadf_pkg::FRAME_W-1:0]      i_frame_index,
    input  logic [sadf_pkg::SLOT_W-1:0]       i_slot_number,
    input  logic                              i_write_failed,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sadf_pkg::STATUS_W-1:0]     o_status,
    output logic [sadf_pkg::SLOT_W-1:0]       o_slot_out,
    output logic                              o_last
);

    import sadf_pkg::*;

    localparam int FW     = $clog2(SLOTS + 1);
    localparam int AW     = $clog2(SLOTS);
    localparam int QFW    = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QN     = MAX_FRAMES * QUEUE_DEPTH;
    localparam int QAW    = (QN > 1) ? $clog2(QN) : 1;
    localparam int FRW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCW    = $clog2(MAX_FRAMES + 1);
    localparam int FC_RST = (FRAME_COUNT_RST > MAX_FRAMES) ? MAX_FRAMES : FRAME_COUNT_RST;

    t_state                r_state, n_state;
    logic [FW-1:0]         r_slot_count;
    logic [FCW-1:0]        r_frame_count;
    logic [FW-1:0]         r_fill, n_fill;
    logic [FW-1:0]         r_low, n_low;
    logic [QFW-1:0]        r_qfill [MAX_FRAMES];
    logic [QFW-1:0]        n_qfill [MAX_FRAMES];
    logic [ACTION_W-1:0]   r_action;
    logic [FRAME_W-1:0]    r_frame;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_wfail;
    logic [QIW-1:0]        r_idx, n_idx;
    logic                  r_use_init;
    logic [SLOT_W-1:0]     r_init_val;
    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_slot_out, n_slot_out;
    logic                  r_last, n_last;

    logic                  st_we;
    logic [AW-1:0]         st_waddr, st_raddr;
    logic [SLOT_W-1:0]     st_wdata, st_rdata;
    logic                  q_we;
    logic [QAW-1:0]        q_waddr, q_raddr;
    logic [SLOT_W-1:0]     q_wdata, q_rdata;

    logic                  out_can, in_acc, frame_ok, slot_ok, flush_last;
    logic [QFW-1:0]        cur_fill;
    logic [FRAME_W-1:0]    rd_frame;
    logic [FW-1:0]         cfg_sc;
    logic [FCW-1:0]        cfg_fc;

    sadf_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W), .AW(AW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    sadf_ram #(.DEPTH(QN), .WIDTH(SLOT_W), .AW(QAW)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign out_can    = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign frame_ok   = (32'(r_frame) < 32'(r_frame_count)) && (32'(r_frame) < MAX_FRAMES);
    assign slot_ok    = 32'(r_slot) < 32'(r_slot_count);
    assign cur_fill   = r_qfill[FRW'(r_frame)];
    assign flush_last = (QFW'(r_idx) + QFW'(1)) == cur_fill;

    // stack top is read every cycle; valid in S_EXEC since the fill holds
    assign st_raddr = AW'(r_fill - FW'(1));
    // queue read address tracks the next index, so q_rdata matches r_idx
    assign rd_frame = in_acc ? i_frame_index : r_frame;
    assign q_raddr  = QAW'(32'(rd_frame) * QUEUE_DEPTH + 32'(n_idx));

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_sc = FW'(1);
        end else if (32'(i_cfg_data) > SLOTS) begin
            cfg_sc = FW'(SLOTS);
        end else begin
            cfg_sc = FW'(i_cfg_data);
        end
        if (i_cfg_data[2:0] == 3'd0) begin
            cfg_fc = FCW'(1);
        end else if (32'(i_cfg_data[2:0]) > MAX_FRAMES) begin
            cfg_fc = FCW'(MAX_FRAMES);
        end else begin
            cfg_fc = FCW'(i_cfg_data[2:0]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_low       = r_low;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_slot_out  = r_slot_out;
        n_last      = r_last;
        for (int f = 0; f < MAX_FRAMES; f++) begin
            n_qfill[f] = r_qfill[f];
        end
        st_we    = 1'b0;
        st_waddr = AW'(r_fill);
        st_wdata = q_rdata;
        q_we     = 1'b0;
        q_waddr  = QAW'(32'(r_frame) * QUEUE_DEPTH + 32'(cur_fill));
        q_wdata  = r_slot;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    if (i_action != ACT_UNUSED) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_can) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_slot_out  = '0;
                    case (r_action)
                        ACT_ALLOC: begin
                            if (r_fill == '0) begin
                                n_status = ST_POOL_EMPTY;
                            end else if (r_wfail) begin
                                n_status = ST_WRITE_FAIL;
                            end else begin
                                n_status   = ST_ALLOCATED;
                                n_slot_out = r_use_init ? r_init_val : st_rdata;
                                n_fill     = r_fill - FW'(1);
                                if ((r_fill - FW'(1)) < r_low) begin
                                    n_low = r_fill - FW'(1);
                                end
                            end
                        end
                        ACT_RELEASE: begin
                            if (!frame_ok || !slot_ok) begin
                                n_status = ST_BAD;
                            end else if (32'(cur_fill) >= QUEUE_DEPTH) begin
                                n_status = ST_QUEUE_FULL;
                            end else begin
                                q_we                    = 1'b1;
                                n_qfill[FRW'(r_frame)]  = cur_fill + QFW'(1);
                                n_status                = ST_QUEUED;
                                n_slot_out              = r_slot;
                            end
                        end
                        ACT_FLUSH: begin
                            if (!frame_ok) begin
                                n_status = ST_BAD;
                            end else if (cur_fill == '0) begin
                                n_status = ST_NOTHING;
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_FLUSH;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (out_can) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CLEARED;
                    n_slot_out  = q_rdata;
                    n_last      = flush_last;
                    // push onto a full stack drops the slot
                    if (r_fill < r_slot_count) begin
                        st_we  = 1'b1;
                        n_fill = r_fill + FW'(1);
                    end
                    if (flush_last) begin
                        n_qfill[FRW'(r_frame)] = '0;
                        n_state                = S_IDLE;
                    end else begin
                        n_idx = r_idx + QIW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // refill: entries below the low-water mark read as init
        if (i_cfg_we && (i_cfg_index == CFG_SLOT_COUNT)) begin
            n_fill = cfg_sc;
            n_low  = cfg_sc;
            for (int f = 0; f < MAX_FRAMES; f++) begin
                n_qfill[f] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot_count  <= FW'(SLOTS);
            r_frame_count <= FCW'(FC_RST);
            r_fill        <= FW'(SLOTS);
            r_low         <= FW'(SLOTS);
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            for (int f = 0; f < MAX_FRAMES; f++) begin
                r_qfill[f] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_low       <= n_low;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            for (int f = 0; f < MAX_FRAMES; f++) begin
                r_qfill[f] <= n_qfill[f];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLOT_COUNT: begin
                        r_slot_count <= cfg_sc;
                    end
                    CFG_FRAME_COUNT: begin
                        r_frame_count <= cfg_fc;
                    end
                    default: begin
                        r_frame_count <= r_frame_count;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_frame  <= i_frame_index;
            r_slot   <= i_slot_number;
            r_wfail  <= i_write_failed;
        end
        // top entry never rewritten since refill -> slot_count-1-index
        r_use_init <= (r_fill <= r_low);
        r_init_val <= SLOT_W'(r_slot_count - r_fill);
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot_out  = r_slot_out;
    assign o_last      = r_last;

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_slot_count)
        else $error("stack fill above slot_count");

    a_low_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_fill)
        else $error("low-water mark above stack fill");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (32'(r_idx) < 32'(cur_fill)))
        else $error("flush index past queue fill");

    a_push_only_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> ((r_state == S_FLUSH) && (r_fill < r_slot_count)))
        else $error("stack push outside flush or onto full stack");

    a_queue_wr_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_we |-> ((r_state == S_EXEC) && (r_action == ACT_RELEASE)))
        else $error("queue write outside release");

endmodule

// ===== hdl/sadf_ram.sv =====
// ----------------------------------------------------------------------------
// sadf_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sadf_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 10,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb_slot_allocator_deferred_free_top.sv =====
// ----------------------------------------------------------------------------
// tb_slot_allocator_deferred_free_top: self-checking bench for the slot allocator
// Drives allocate, release and flush requests with random gaps and output
// stalls, predicts every result beat with a behavioural free-list model and
// compares the beats in order. Runs several slot/frame settings, extremes too.
// ----------------------------------------------------------------------------
module tb_slot_allocator_deferred_free_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sadf_pkg::*;

    localparam int SLOTS         = SLOTS_DEF;
    localparam int MAX_FRAMES    = MAX_FRAMES_DEF;
    localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result_beat;

    class alloc_scoreboard;
        int                slot_cnt;
        int                frame_cnt;
        logic [SLOT_W-1:0] free_stack [SLOTS];
        int                stack_fill;
        logic [SLOT_W-1:0] rel_queue [MAX_FRAMES][QUEUE_DEPTH];
        int                q_fill [MAX_FRAMES];
        logic [SLOT_W-1:0] held [$];         // slots handed out, for release picks
        t_result_beat      expected_beats [$];
        int                errors;

        function new();
            slot_cnt  = SLOTS;
            frame_cnt = (FRAME_COUNT_RST > MAX_FRAMES) ? MAX_FRAMES : FRAME_COUNT_RST;
            errors    = 0;
            refill();
        endfunction

        function void refill();
            for (int i = 0; i < SLOTS; i++)
                free_stack[i] = (i < slot_cnt) ? SLOT_W'(slot_cnt - 1 - i) : '0;
            stack_fill = slot_cnt;
            for (int f = 0; f < MAX_FRAMES; f++)
                q_fill[f] = 0;
            held.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int v;
            if (idx == CFG_SLOT_COUNT) begin
                v = int'(data);
                if (v < 1) v = 1;
                if (v > SLOTS) v = SLOTS;
                slot_cnt = v;
                refill();
            end else begin
                v = int'(data[2:0]);
                if (v < 1) v = 1;
                if (v > MAX_FRAMES) v = MAX_FRAMES;
                frame_cnt = v;
            end
        endfunction

        function void expect_beat(t_status st, logic [SLOT_W-1:0] s, logic l);
            t_result_beat b;
            b.status = st;
            b.slot   = s;
            b.last   = l;
            expected_beats.insert(expected_beats.size(), b);
        endfunction

        function void predict_request(logic [ACTION_W-1:0] act, logic [FRAME_W-1:0] frame,
                                      logic [SLOT_W-1:0] slot, logic wf);
            int n;
            logic [SLOT_W-1:0] s;
            case (act)
                ACT_ALLOC: begin
                    if (stack_fill == 0) begin
                        expect_beat(ST_POOL_EMPTY, '0, 1'b1);
                    end else if (wf) begin
                        expect_beat(ST_WRITE_FAIL, '0, 1'b1);
                    end else begin
                        stack_fill--;
                        s = free_stack[stack_fill];
                        held.insert(held.size(), s);
                        expect_beat(ST_ALLOCATED, s, 1'b1);
                    end
                end
                ACT_RELEASE: begin
                    if (int'(frame) >= frame_cnt || int'(slot) >= slot_cnt) begin
                        expect_beat(ST_BAD, '0, 1'b1);
                    end else if (q_fill[frame] >= QUEUE_DEPTH) begin
                        expect_beat(ST_QUEUE_FULL, '0, 1'b1);
                    end else begin
                        rel_queue[frame][q_fill[frame]] = slot;
                        q_fill[frame]++;
                        expect_beat(ST_QUEUED, slot, 1'b1);
                    end
                end
                ACT_FLUSH: begin
                    if (int'(frame) >= frame_cnt) begin
                        expect_beat(ST_BAD, '0, 1'b1);
                    end else if (q_fill[frame] == 0) begin
                        expect_beat(ST_NOTHING, '0, 1'b1);
                    end else begin
                        n = q_fill[frame];
                        for (int i = 0; i < n; i++) begin
                            s = rel_queue[frame][i];
                            // a full stack drops the slot, the beat still goes out
                            if (stack_fill < slot_cnt && stack_fill < SLOTS) begin
                                free_stack[stack_fill] = s;
                                stack_fill++;
                            end
                            expect_beat(ST_CLEARED, s, (i == n - 1));
                        end
                        q_fill[frame] = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                 logic last);
            t_result_beat want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat status %0d slot %0d last %0d",
                         $time, status, slot, last);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (slot !== want.slot) begin
                $display("%0t: slot_out expected %0d actual %0d", $time, want.slot, slot);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [ACTION_W-1:0]   action        = '0;
    logic [FRAME_W-1:0]    frame_index   = '0;
    logic [SLOT_W-1:0]     slot_number   = '0;
    logic                  write_failed  = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot_out;
    logic                  last;

    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;

    alloc_scoreboard sb = new();

    slot_allocator_deferred_free_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_frame_index (frame_index),
        .i_slot_number (slot_number),
        .i_write_failed(write_failed),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_slot_out    (slot_out),
        .o_last        (last)
    );

    always #1 i_clk = ~i_clk;

    // mostly short idles, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 15);
        if (r < 6) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] frame,
                             input logic [SLOT_W-1:0] slot, input logic wf);
        int gap;
        gap = gaps_on ? idle_cycles() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        frame_index  <= frame;
        slot_number  <= slot;
        write_failed <= wf;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.predict_request(act, frame, slot, wf);
    endtask

    // drop valid, let every expected beat arrive and the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int w_alloc, input int w_rel, input int w_flush);
        logic [ACTION_W-1:0] act;
        logic [FRAME_W-1:0]  frame;
        logic [SLOT_W-1:0]   slot;
        logic                wf;
        int                  r;
        int                  k;
        for (int i = 0; i < n; i++) begin
            act   = ACT_ALLOC;
            frame = FRAME_W'($urandom_range(0, 3));
            slot  = SLOT_W'($urandom_range(0, SLOTS - 1));
            wf    = 1'b0;
            r     = $urandom_range(0, w_alloc + w_rel + w_flush - 1);
            if ($urandom_range(0, 9) == 0) begin
                // noise: anything the fields allow
                act = ACTION_W'($urandom_range(0, 3));
                wf  = 1'($urandom_range(0, 1));
            end else if (r < w_alloc) begin
                act = ACT_ALLOC;
                wf  = ($urandom_range(0, 15) == 0);
            end else if (r < w_alloc + w_rel) begin
                act   = ACT_RELEASE;
                frame = FRAME_W'($urandom_range(0, sb.frame_cnt - 1));
                if (sb.held.size() != 0 && $urandom_range(0, 3) != 0) begin
                    k    = $urandom_range(0, sb.held.size() - 1);
                    slot = sb.held[k];
                    sb.held.delete(k);
                end else begin
                    slot = SLOT_W'($urandom_range(0, sb.slot_cnt - 1));
                end
            end else begin
                act   = ACT_FLUSH;
                frame = FRAME_W'($urandom_range(0, sb.frame_cnt - 1));
            end
            send_item(act, frame, slot, wf);
        end
    endtask

    // result side: check accepted beats, drive stall
    initial begin : result_sink
        int run_left;
        int hold_left;
        bit stalling;
        run_left  = 0;
        hold_left = 0;
        stalling  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall)
                sb.check_beat(status, slot_out, last);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall   <= 1'b1;
            end else if (!gaps_on) begin
                out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    run_left = stalling ? idle_cycles() : $urandom_range(1, 12);
                    if (run_left == 0) begin
                        stalling = 1'b0;
                        run_left = $urandom_range(1, 12);
                    end
                end
                run_left--;
                out_stall <= stalling;
            end
        end
    end

    initial begin : run_limit
        #(TIMEOUT_NS);
        $display("FAIL slot_allocator_deferred_free_top");
        $finish;
    end

    initial begin : main_flow
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 1024 slots, 3 frames
        send_item(ACT_ALLOC,   2'd3, 10'd1023, 1'b0);
        send_item(ACT_ALLOC,   2'd0, 10'd0,    1'b1);  // write failure
        send_item(ACT_ALLOC,   2'd0, 10'd0,    1'b0);
        send_item(ACT_RELEASE, 2'd0, 10'd0,    1'b0);
        send_item(ACT_RELEASE, 2'd0, 10'd1,    1'b1);
        send_item(ACT_RELEASE, 2'd3, 10'd5,    1'b0);  // frame out of range
        send_item(ACT_FLUSH,   2'd3, 10'd0,    1'b0);
        send_item(ACT_FLUSH,   2'd1, 10'd0,    1'b0);  // empty queue
        send_item(ACT_UNUSED,  2'd3, 10'd1023, 1'b1);  // ignored
        send_item(ACT_FLUSH,   2'd0, 10'd0,    1'b0);
        send_item(ACT_RELEASE, 2'd2, 10'd1023, 1'b0);
        send_item(ACT_FLUSH,   2'd2, 10'd0,    1'b0);  // push onto a full stack
        settle();

        write_reg(CFG_SLOT_COUNT,  11'd3);
        write_reg(CFG_FRAME_COUNT, 11'd1);
        send_item(ACT_RELEASE, 2'd0, 10'd3, 1'b0);     // slot out of range
        send_item(ACT_RELEASE, 2'd1, 10'd0, 1'b0);
        repeat (4) send_item(ACT_ALLOC, 2'd0, 10'd0, 1'b0);
        send_item(ACT_ALLOC,   2'd0, 10'd0, 1'b1);     // empty pool wins over failure
        send_item(ACT_RELEASE, 2'd0, 10'd2, 1'b0);
        send_item(ACT_FLUSH,   2'd0, 10'd0, 1'b0);
        settle();

        // clamped extremes, with the receiver holding off early on
        write_reg(CFG_SLOT_COUNT,  11'd2047);
        write_reg(CFG_FRAME_COUNT, 11'd7);
        hold_request = 1'b1;
        run_random(100, 40, 40, 20);
        settle();

        write_reg(CFG_SLOT_COUNT,  11'd0);
        write_reg(CFG_FRAME_COUNT, 11'd0);
        run_random(50, 40, 40, 20);
        settle();

        // release heavy so queues fill up
        write_reg(CFG_SLOT_COUNT,  11'd16);
        write_reg(CFG_FRAME_COUNT, 11'd1);
        run_random(100, 10, 88, 2);
        settle();

        gaps_on = 1'b0;
        write_reg(CFG_SLOT_COUNT,  11'd2);
        write_reg(CFG_FRAME_COUNT, 11'd2);
        run_random(60, 40, 40, 20);
        settle();
        gaps_on = 1'b1;

        write_reg(CFG_SLOT_COUNT,  11'd1024);
        write_reg(CFG_FRAME_COUNT, 11'h7FB);         // low bits give 3
        run_random(80, 45, 35, 20);
        settle();

        write_reg(CFG_SLOT_COUNT,  11'd64);
        write_reg(CFG_FRAME_COUNT, 11'd4);
        run_random(60, 30, 50, 20);
        settle();

        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("PASS slot_allocator_deferred_free_top");
        end else begin
            $display("FAIL slot_allocator_deferred_free_top");
        end
        $finish;
    end

endmodule
